// ===== sv/dsel_pkg.sv =====
// dsel_pkg: widths, codes and shared types of the date sorted entry list
// no dependencies; compiled first
package dsel_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned OPC_W         = 2;
    localparam int unsigned DATE_W        = 31;
    localparam int unsigned NUM_W         = 16;
    localparam int unsigned STATUS_W      = 3;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATE_W-1:0] date;
        logic [NUM_W-1:0]  number;
    } entry_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [DATE_W-1:0] date;
        logic [NUM_W-1:0]  number;
    } cell_ctrl_t;

endpackage

// ===== sv/dsel_if.sv =====
// dsel_in_if and dsel_out_if: valid/ready channels of the entry list
// depends on dsel_pkg
interface dsel_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsel_pkg::OPC_W-1:0]    opcode;
    logic [dsel_pkg::DATE_W-1:0]   entry_date;
    logic [dsel_pkg::NUM_W-1:0]    item_number;

    modport source (output valid, output opcode, output entry_date, output item_number,
                    input ready);
    modport sink   (input valid, input opcode, input entry_date, input item_number,
                    output ready);
endinterface

interface dsel_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsel_pkg::STATUS_W-1:0] status;
    logic [dsel_pkg::DATE_W-1:0]   out_date;
    logic [dsel_pkg::NUM_W-1:0]    out_number;
    logic                          last;

    modport source (output valid, output status, output out_date, output out_number,
                    output last, input ready);
    modport sink   (input valid, input status, input out_date, input out_number,
                    input last, output ready);
endinterface

// ===== sv/date_sorted_entry_list.sv =====
// date_sorted_entry_list: top level, chain of entry cells with control and result register
// depends on dsel_pkg, dsel_if, dsel_cell and dsel_prefix_or
//
// Usage
//   in_ch  (sink): opcode, entry_date, item_number; a beat is taken on valid && ready.
//     insert keeps entries in ascending date, a new entry ahead of equal dates;
//     remove deletes the first entry with a matching item number; list emits all.
//   out_ch (source): status, out_date, out_number, last; one beat per result.
//   Insert and remove compare in every cell at once and finish in the accept
//   cycle; their result beat is valid in the next cycle. An item with opcode
//   three is taken and gives no beat.
//   A list is taken in its accept cycle, then gives one beat per cycle while
//   out_ch is free, as the chain rotates its entries past the head cell; the
//   next item is taken once the last beat is loaded. An empty list gives one beat.
//   Throughput is one item per cycle for insert and remove while out_ch is ready,
//   set by the single result register; a list is bounded by the one-entry head read.
//   Reset empties the list at once; no clearing pass is needed.
//   When out_ch stalls the result register holds and in_ch.ready drops until
//   the register is free; a list pauses its rotation meanwhile.
module date_sorted_entry_list #(
    parameter int unsigned DEPTH = dsel_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    dsel_in_if.sink           in_ch,
    dsel_out_if.source        out_ch
);
    import dsel_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    entry_t           cells [DEPTH];
    logic [DEPTH-1:0] keep_vec;
    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] seen_vec;
    logic [DEPTH-1:0] valid_vec;
    cell_ctrl_t       ctrl;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DATE_W-1:0] out_date_reg, out_date_next;
    logic [NUM_W-1:0]  out_number_reg, out_number_next;
    logic              out_last_reg, out_last_next;

    logic out_free;
    logic in_fire;
    logic emit;
    logic full;
    logic found;
    logic list_last;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_i;
        entry_t right_i;
        logic   left_keep_i;

        if (i == 0)
        begin : g_first
            assign left_i      = '0;
            assign left_keep_i = 1'b1;
        end
        else
        begin : g_mid
            assign left_i      = cells[i-1];
            assign left_keep_i = keep_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_i = '0;
        end
        else
        begin : g_inner
            assign right_i = cells[i+1];
        end

        dsel_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_i),
            .left_keep (left_keep_i),
            .right     (right_i),
            .head      (cells[0]),
            .seen      (seen_vec[i]),
            .cur       (cells[i]),
            .keep      (keep_vec[i]),
            .match     (match_vec[i])
        );

        assign valid_vec[i] = cells[i].valid;
    end

    dsel_prefix_or #(
        .N (DEPTH)
    ) u_prefix (
        .req  (match_vec),
        .seen (seen_vec)
    );

    assign full      = cells[DEPTH-1].valid;
    assign found     = seen_vec[DEPTH-1];
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign list_last = (idx_reg == (count_reg - CW'(1)));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ctrl.cmd        = CMD_HOLD;
        ctrl.date       = in_ch.entry_date;
        ctrl.number     = in_ch.item_number;
        emit            = 1'b0;
        out_status_next = ST_DONE;
        out_date_next   = '0;
        out_number_next = '0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.opcode)
                        OP_INSERT:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            emit = 1'b1;
                            if (found)
                            begin
                                ctrl.cmd   = CMD_REMOVE;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                emit            = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    ctrl.cmd        = CMD_ROTATE;
                    out_status_next = ST_ENTRY;
                    out_date_next   = cells[0].date;
                    out_number_next = cells[0].number;
                    out_last_next   = list_last;
                    idx_next        = idx_reg + CW'(1);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_date_reg   <= out_date_next;
            out_number_reg <= out_number_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.out_date   = out_date_reg;
    assign out_ch.out_number = out_number_reg;
    assign out_ch.last       = out_last_reg;

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count differs from occupied cells");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_list_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> !in_ch.ready)
        else $error("input taken during list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.opcode == OP_INSERT) && !full)
            |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not add an entry");

    a_list_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(state_reg == S_LIST)) |-> (out_valid_reg && out_last_reg))
        else $error("list finished without last beat");
endmodule

// ===== sv/dsel_prefix_or.sv =====
// dsel_prefix_or: log-depth prefix OR, seen[i] = OR of req[0..i]
// no package dependency
module dsel_prefix_or #(
    parameter int unsigned N = 16
) (
    input  logic [N-1:0] req,
    output logic [N-1:0] seen
);
    localparam int unsigned LEVELS = (N > 1) ? $clog2(N) : 1;

    wire [N-1:0] stage [0:LEVELS];

    assign stage[0] = req;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        for (genvar i = 0; i < N; i++)
        begin : g_bit
            if (i >= (1 << l))
            begin : g_or
                assign stage[l+1][i] = stage[l][i] | stage[l][i-(1 << l)];
            end
            else
            begin : g_pass
                assign stage[l+1][i] = stage[l][i];
            end
        end
    end

    assign seen = stage[LEVELS];
endmodule

// ===== sv/dsel_cell.sv =====
// dsel_cell: one slot of the sorted chain, holds one entry
// depends on dsel_pkg; neighbours are wired by the top level
module dsel_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsel_pkg::cell_ctrl_t ctrl,
    input  dsel_pkg::entry_t     left,
    input  logic                 left_keep,
    input  dsel_pkg::entry_t     right,
    input  dsel_pkg::entry_t     head,
    input  logic                 seen,
    output dsel_pkg::entry_t     cur,
    output logic                 keep,
    output logic                 match
);
    import dsel_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATE_W-1:0] date_reg, date_next;
    logic [NUM_W-1:0]  number_reg, number_next;

    assign cur   = '{valid: valid_reg, date: date_reg, number: number_reg};
    assign keep  = valid_reg && (date_reg < ctrl.date);
    assign match = valid_reg && (number_reg == ctrl.number);

    always_comb
    begin
        valid_next  = valid_reg;
        date_next   = date_reg;
        number_next = number_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next  = 1'b1;
                        date_next   = ctrl.date;
                        number_next = ctrl.number;
                    end
                    else
                    begin
                        valid_next  = left.valid;
                        date_next   = left.date;
                        number_next = left.number;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (seen)
                begin
                    valid_next  = right.valid;
                    date_next   = right.date;
                    number_next = right.number;
                end
            end
            CMD_ROTATE:
            begin
                if (valid_reg)
                begin
                    if (right.valid)
                    begin
                        date_next   = right.date;
                        number_next = right.number;
                    end
                    else
                    begin
                        date_next   = head.date;
                        number_next = head.number;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg   <= date_next;
        number_reg <= number_next;
    end
endmodule
